### hw/rtl/tlrpc_pkg.sv
`timescale 1ns / 1ps

package tlrpc_pkg;

	// Configuration port geometry.
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_MAX_STEP   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CUR_LIMIT  = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_TEMP_LIMIT = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_FULL_SCALE = 2'd3;

	// Configuration reset values.
	localparam logic [14:0]        MAX_STEP_RST   = 15'd256;
	localparam logic signed [15:0] CUR_LIMIT_RST  = 16'sd32767;
	localparam logic signed [15:0] TEMP_LIMIT_RST = 16'sd32767;
	localparam logic [14:0]        FULL_SCALE_RST = 15'd25600;

	// Number of quotient bits produced by the serial divider.
	localparam int DivSteps = 16;
	localparam int DivCntW  = $clog2(DivSteps + 1);

	// One control tick.
	typedef struct packed {
		logic signed [15:0] phase_current;
		logic signed [15:0] temperature;
		logic signed [15:0] driver_torque;
		logic signed [15:0] safety_torque;
		logic signed [15:0] thermal_torque;
	} in_item_t;

	// One result.
	typedef struct packed {
		logic signed [15:0] final_torque;
		logic [16:0]        duty_a;
		logic [16:0]        duty_b;
		logic [16:0]        duty_c;
		logic               fault_active;
	} out_item_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic capture;
		logic calc;
		logic limit;
		logic div_init;
		logic div_step;
		logic load_out;
		logic out_run;
		logic out_fault;
	} ctrl_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic trip;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

### hw/rtl/torque_limit_rate_pwm_controller_core.sv
`timescale 1ns / 1ps

// Torque limit, rate limit and PWM duty controller.
// Input channel (in_valid/in_ready/in_data): one control tick per transfer,
// carrying phase current, temperature and three torque requests.
// Output channel (out_valid/out_ready/out_data): exactly one result per tick,
// with final torque, three phase duties and the fault flag.
// Configuration port (cfg_wr_en/cfg_index/cfg_wdata): single-cycle register
// writes, to be issued only while no tick is in flight.
// Ticks outside run mode go from capture through calc to finish; a run tick
// adds the limit state, where a trip sends it to finish, or else the divider
// init and divide states, with no divide steps when the duty saturates or
// the torque is zero. A new tick is taken only once the last is loaded; the
// 16-step serial divider that scales torque into duty sets the worst case.
// Reset puts the sequencer in init mode, clears the previous torque and
// loads the register defaults; the output register comes up empty.
// The output register lets the next tick be taken while a result waits; if
// the receiver stalls, the finished tick waits before its result is loaded.
module torque_limit_rate_pwm_controller_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tlrpc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [tlrpc_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  tlrpc_pkg::in_item_t             in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tlrpc_pkg::out_item_t            out_data
);
	import tlrpc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Tick sequencer and handshake control.
	tlrpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Limits, rate limit, serial divider and output register.
	tlrpc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### hw/rtl/tlrpc_dpath.sv
`timescale 1ns / 1ps

module tlrpc_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tlrpc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [tlrpc_pkg::CfgDataW-1:0]  cfg_wdata,
	input  tlrpc_pkg::in_item_t             in_data,
	input  tlrpc_pkg::ctrl_cmd_t            cmd,
	output tlrpc_pkg::dp_status_t           status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output tlrpc_pkg::out_item_t            out_data
);
	import tlrpc_pkg::*;

	logic [14:0]        max_step_q;
	logic signed [15:0] cur_lim_q;
	logic signed [15:0] temp_lim_q;
	logic [14:0]        full_scale_q;

	in_item_t           in_q;
	logic               trip_q;
	logic signed [15:0] target_q;
	logic signed [15:0] prev_q;
	logic signed [15:0] torque_q;

	logic               neg_q;
	logic [15:0]        rem_q;
	logic [16:0]        quot_q;
	logic [DivCntW-1:0] cnt_q;

	out_item_t          out_q;
	logic               out_valid_q;

	logic signed [15:0] min_ab;
	logic signed [15:0] min_abc;
	logic               trip;
	logic signed [16:0] prev_x;
	logic signed [16:0] step_x;
	logic signed [16:0] delta;
	logic signed [16:0] sum_up;
	logic signed [16:0] sum_dn;
	logic signed [15:0] limited;
	logic [15:0]        mag;
	logic [16:0]        rem_dbl;
	logic               rem_ge;
	logic signed [17:0] base;
	logic [17:0]        ofs;
	logic [16:0]        duty_a;
	logic [16:0]        duty_b;

	// Configuration registers, written by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q   <= MAX_STEP_RST;
			cur_lim_q    <= CUR_LIMIT_RST;
			temp_lim_q   <= TEMP_LIMIT_RST;
			full_scale_q <= FULL_SCALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_STEP:   max_step_q   <= cfg_wdata[14:0];
				REG_CUR_LIMIT:  cur_lim_q    <= $signed(cfg_wdata);
				REG_TEMP_LIMIT: temp_lim_q   <= $signed(cfg_wdata);
				REG_FULL_SCALE: full_scale_q <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// Trip check and the smallest of the three torque requests.
	always_comb begin
		min_ab  = (in_q.driver_torque < in_q.safety_torque) ?
			in_q.driver_torque : in_q.safety_torque;
		min_abc = (min_ab < in_q.thermal_torque) ? min_ab : in_q.thermal_torque;
		trip    = (in_q.phase_current > cur_lim_q) || (in_q.temperature > temp_lim_q);
	end

	// Rate limit against the previous torque, at 17 bits so nothing wraps.
	always_comb begin
		prev_x = {prev_q[15], prev_q};
		step_x = $signed({2'b00, max_step_q});
		delta  = $signed({target_q[15], target_q}) - prev_x;
		sum_up = prev_x + step_x;
		sum_dn = prev_x - step_x;
		if (delta > step_x) begin
			limited = sum_up[15:0];
		end else if (delta < -step_x) begin
			limited = sum_dn[15:0];
		end else begin
			limited = target_q;
		end
	end

	// Divider operand and one restoring step.
	always_comb begin
		mag     = torque_q[15] ? (~$unsigned(torque_q) + 16'd1) : $unsigned(torque_q);
		rem_dbl = {rem_q, 1'b0};
		rem_ge  = (rem_dbl >= {2'b00, full_scale_q});
	end

	// Signed duty base and the phase duties; phase C reuses the phase B duty.
	always_comb begin
		base   = neg_q ? -$signed({1'b0, quot_q}) : $signed({1'b0, quot_q});
		ofs    = $unsigned(base) + 18'd65536;
		duty_a = ofs[17:1];
		duty_b = 17'd49152 - {1'b0, ofs[17:2]};
	end

	// Operand and intermediate registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.calc) begin
			trip_q   <= trip;
			target_q <= min_abc;
		end
		if (cmd.limit) begin
			torque_q <= limited;
		end
	end

	// Previous torque register; reset clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.limit) begin
			prev_q <= limited;
		end
	end

	// Serial divider: magnitude * 65536 / full scale, saturating at 65536.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			if (torque_q == 16'sd0 || full_scale_q == 15'd0 ||
					mag >= {1'b0, full_scale_q}) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= DivCntW'(DivSteps);
			end
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - DivCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= torque_q[15];
			rem_q <= mag;
			if (torque_q == 16'sd0) begin
				quot_q <= '0;
			end else if (full_scale_q == 15'd0 || mag >= {1'b0, full_scale_q}) begin
				quot_q <= 17'd65536;
			end else begin
				quot_q <= '0;
			end
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? 16'(rem_dbl - {2'b00, full_scale_q}) : rem_dbl[15:0];
			quot_q <= {quot_q[15:0], rem_ge};
		end
	end

	// Output register: filled on command, emptied by an output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.out_run) begin
				out_q.final_torque <= torque_q;
				out_q.duty_a       <= duty_a;
				out_q.duty_b       <= duty_b;
				out_q.duty_c       <= duty_b;
			end else begin
				out_q.final_torque <= '0;
				out_q.duty_a       <= '0;
				out_q.duty_b       <= '0;
				out_q.duty_c       <= '0;
			end
			out_q.fault_active <= cmd.out_fault;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign status.trip     = trip_q;
	assign status.div_done = (cnt_q == '0);
	assign status.out_free = !out_valid_q || out_ready;

`ifndef SYNTH
	// A step is never issued once the quotient is complete.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> cnt_q != '0)
		else $error("divider stepped past its last bit");

	// Duties of a run result stay within the full duty range.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && cmd.out_run |-> duty_a <= 17'd65536 && duty_b <= 17'd49152)
		else $error("duty out of range");

	// A result held under stall does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(out_q))
		else $error("held result changed");
`endif

endmodule

### hw/rtl/tlrpc_ctrl.sv
`timescale 1ns / 1ps

module tlrpc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  tlrpc_pkg::dp_status_t   status,
	output tlrpc_pkg::ctrl_cmd_t    cmd
);
	import tlrpc_pkg::*;

	// Operating modes of the control sequencer.
	localparam logic [2:0] MODE_INIT     = 3'd0;
	localparam logic [2:0] MODE_READY    = 3'd1;
	localparam logic [2:0] MODE_RUN      = 3'd2;
	localparam logic [2:0] MODE_FAULT    = 3'd3;
	localparam logic [2:0] MODE_SHUTDOWN = 3'd4;

	// Per-tick processing states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CALC   = 3'd1;
	localparam logic [2:0] ST_LIMIT  = 3'd2;
	localparam logic [2:0] ST_DINIT  = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic [2:0] mode_q;
	logic [2:0] mode_nxt;
	logic       res_run_q;
	logic       res_run_nxt;
	logic       res_fault_q;
	logic       res_fault_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// Next state, mode update and datapath commands.
	always_comb begin
		state_nxt     = state_q;
		mode_nxt      = mode_q;
		res_run_nxt   = res_run_q;
		res_fault_nxt = res_fault_q;
		cmd           = '0;
		cmd.out_run   = res_run_q;
		cmd.out_fault = res_fault_q;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nxt = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc      = 1'b1;
				res_run_nxt   = 1'b0;
				res_fault_nxt = 1'b0;
				state_nxt     = ST_FINISH;
				case (mode_q)
					MODE_INIT:  mode_nxt = MODE_READY;
					MODE_READY: mode_nxt = MODE_RUN;
					MODE_RUN:   state_nxt = ST_LIMIT;
					MODE_FAULT: begin
						res_fault_nxt = 1'b1;
						mode_nxt      = MODE_SHUTDOWN;
					end
					default: ;
				endcase
			end
			ST_LIMIT: begin
				if (status.trip) begin
					mode_nxt  = MODE_FAULT;
					state_nxt = ST_FINISH;
				end else begin
					cmd.limit   = 1'b1;
					res_run_nxt = 1'b1;
					state_nxt   = ST_DINIT;
				end
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_nxt    = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_INIT;
			res_run_q   <= 1'b0;
			res_fault_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			mode_q      <= mode_nxt;
			res_run_q   <= res_run_nxt;
			res_fault_q <= res_fault_nxt;
		end
	end

`ifndef SYNTH
	// A fault result is only delivered once the sequencer has shut down.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && cmd.out_fault |-> mode_q == MODE_SHUTDOWN)
		else $error("fault result outside shutdown");

	// A result is loaded only when the output register can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result loaded over a held result");

	// A run result and a fault flag never come together.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(cmd.out_run && cmd.out_fault))
		else $error("run result flagged as fault");

	// After a completed load the sequencer is ready for the next tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> in_ready)
		else $error("not idle after result load");
`endif

endmodule
